>>> sv/bilinear_rgb_sample_normalize_unit_macros.svh
// Assertion macros shared by the bilinear sampler RTL.
`ifndef BILINEAR_RGB_SAMPLE_NORMALIZE_UNIT_MACROS_SVH
`define BILINEAR_RGB_SAMPLE_NORMALIZE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BRSN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BRSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/brsn_pkg.sv
// Shared constants and types of the bilinear RGB sampler.
package brsn_pkg;

   localparam int FRAC_BITS     = 12;
   localparam int OUT_FRAC_BITS = 12;

   localparam int COORD_W     = 13;
   localparam int FRAC_W      = 12;
   localparam int PIXEL_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int NORM_W      = 16;
   localparam int DIM_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CHANNEL_ORDER = 2'd2
   } csr_index_type;

   typedef enum logic {
      ORDER_RGB = 1'b0,
      ORDER_BGR = 1'b1
   } channel_order_type;

   // Mean and standard deviation in thousandths, red, green, blue.
   localparam longint MEAN_MILLI [NUM_CHAN] = '{123675, 116280, 103530};
   localparam longint STD_MILLI  [NUM_CHAN] = '{58395, 57120, 57375};

endpackage

>>> sv/brsn_if.sv
// Request and response channel interfaces of the bilinear sampler.
interface brsn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [brsn_pkg::COORD_W-1:0]  corner_x;
   logic signed [brsn_pkg::COORD_W-1:0]  corner_y;
   logic [brsn_pkg::FRAC_W-1:0]          frac_x;
   logic [brsn_pkg::FRAC_W-1:0]          frac_y;
   logic [brsn_pkg::PIXEL_W-1:0]         pixel_top_left;
   logic [brsn_pkg::PIXEL_W-1:0]         pixel_top_right;
   logic [brsn_pkg::PIXEL_W-1:0]         pixel_bottom_left;
   logic [brsn_pkg::PIXEL_W-1:0]         pixel_bottom_right;

   modport source (
      output valid, corner_x, corner_y, frac_x, frac_y, pixel_top_left,
             pixel_top_right, pixel_bottom_left, pixel_bottom_right,
      input  ready
   );
   modport sink (
      input  valid, corner_x, corner_y, frac_x, frac_y, pixel_top_left,
             pixel_top_right, pixel_bottom_left, pixel_bottom_right,
      output ready
   );
endinterface

interface brsn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [brsn_pkg::NORM_W-1:0]  norm_red;
   logic signed [brsn_pkg::NORM_W-1:0]  norm_green;
   logic signed [brsn_pkg::NORM_W-1:0]  norm_blue;

   modport source (
      output valid, norm_red, norm_green, norm_blue,
      input  ready
   );
   modport sink (
      input  valid, norm_red, norm_green, norm_blue,
      output ready
   );
endinterface

>>> sv/brsn_weight.sv
// Stage one: frame bounds check, channel ordering and interpolation weights.
`include "bilinear_rgb_sample_normalize_unit_macros.svh"

module brsn_weight #(
   parameter int FRAC_BITS = brsn_pkg::FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [brsn_pkg::COORD_W-1:0]     corner_x,
   input  logic signed [brsn_pkg::COORD_W-1:0]     corner_y,
   input  logic [brsn_pkg::FRAC_W-1:0]             frac_x,
   input  logic [brsn_pkg::FRAC_W-1:0]             frac_y,
   input  logic [brsn_pkg::PIXEL_W-1:0]            pixel_top_left,
   input  logic [brsn_pkg::PIXEL_W-1:0]            pixel_top_right,
   input  logic [brsn_pkg::PIXEL_W-1:0]            pixel_bottom_left,
   input  logic [brsn_pkg::PIXEL_W-1:0]            pixel_bottom_right,
   input  logic [brsn_pkg::DIM_W-1:0]              frame_width,
   input  logic [brsn_pkg::DIM_W-1:0]              frame_height,
   input  brsn_pkg::channel_order_type             channel_order,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [2:0][brsn_pkg::CHAN_W-1:0]        tl_chan,
   output logic [2:0][brsn_pkg::CHAN_W-1:0]        tr_chan,
   output logic [2:0][brsn_pkg::CHAN_W-1:0]        bl_chan,
   output logic [2:0][brsn_pkg::CHAN_W-1:0]        br_chan,
   output logic [FRAC_BITS:0]                      wx0,
   output logic [FRAC_BITS:0]                      wx1,
   output logic [FRAC_BITS:0]                      wy0,
   output logic [FRAC_BITS:0]                      wy1
);

   localparam int WeightW = FRAC_BITS + 1;
   localparam int FracUse = (FRAC_BITS < brsn_pkg::FRAC_W) ? FRAC_BITS : brsn_pkg::FRAC_W;
   localparam int CoordW1 = brsn_pkg::COORD_W + 1;
   localparam logic [WeightW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};

   logic                                 valid_ff, valid_in;
   logic                                 load;
   logic [CoordW1-1:0]                   x1, y1;
   logic                                 x0_in, x1_in, y0_in, y1_in;
   logic [2:0][brsn_pkg::CHAN_W-1:0]     tl_ff, tr_ff, bl_ff, br_ff;
   logic [2:0][brsn_pkg::CHAN_W-1:0]     tl_in, tr_in, bl_in, br_in;
   logic [WeightW-1:0]                   wx0_ff, wx1_ff, wy0_ff, wy1_ff;
   logic [WeightW-1:0]                   wx0_in, wx1_in, wy0_in, wy1_in;

   // Map stored bytes to red, green, blue; black when off frame.
   function automatic logic [2:0][brsn_pkg::CHAN_W-1:0] pick_rgb(
      input logic [brsn_pkg::PIXEL_W-1:0] pix,
      input logic                         on_frame,
      input brsn_pkg::channel_order_type  order
   );
      logic [2:0][brsn_pkg::CHAN_W-1:0] rgb;
      rgb[1] = pix[15:8];
      if (order == brsn_pkg::ORDER_BGR) begin
         rgb[0] = pix[23:16];
         rgb[2] = pix[7:0];
      end else begin
         rgb[0] = pix[7:0];
         rgb[2] = pix[23:16];
      end
      return on_frame ? rgb : '0;
   endfunction

   assign x1 = {corner_x[brsn_pkg::COORD_W-1], corner_x} + CoordW1'(1);
   assign y1 = {corner_y[brsn_pkg::COORD_W-1], corner_y} + CoordW1'(1);

   always_comb begin
      x0_in = !corner_x[brsn_pkg::COORD_W-1] && (corner_x < $signed({1'b0, frame_width}));
      y0_in = !corner_y[brsn_pkg::COORD_W-1] && (corner_y < $signed({1'b0, frame_height}));
      x1_in = !x1[CoordW1-1] && (x1 < {1'b0, frame_width});
      y1_in = !y1[CoordW1-1] && (y1 < {1'b0, frame_height});
      tl_in = pick_rgb(pixel_top_left,     x0_in && y0_in, channel_order);
      tr_in = pick_rgb(pixel_top_right,    x1_in && y0_in, channel_order);
      bl_in = pick_rgb(pixel_bottom_left,  x0_in && y1_in, channel_order);
      br_in = pick_rgb(pixel_bottom_right, x1_in && y1_in, channel_order);
      wx1_in = WeightW'(frac_x[FracUse-1:0]);
      wy1_in = WeightW'(frac_y[FracUse-1:0]);
      wx0_in = One - wx1_in;
      wy0_in = One - wy1_in;
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tl_ff  <= tl_in;
         tr_ff  <= tr_in;
         bl_ff  <= bl_in;
         br_ff  <= br_in;
         wx0_ff <= wx0_in;
         wx1_ff <= wx1_in;
         wy0_ff <= wy0_in;
         wy1_ff <= wy1_in;
      end
   end

   assign out_valid = valid_ff;
   assign tl_chan   = tl_ff;
   assign tr_chan   = tr_ff;
   assign bl_chan   = bl_ff;
   assign br_chan   = br_ff;
   assign wx0       = wx0_ff;
   assign wx1       = wx1_ff;
   assign wy0       = wy0_ff;
   assign wy1       = wy1_ff;

   `BRSN_ASSERT_NEXT(a_left_off_frame, clock, reset, load && corner_x[brsn_pkg::COORD_W-1], (tl_ff == '0) && (bl_ff == '0), "left neighbors of a negative corner not black")
   `BRSN_ASSERT_SAME(a_weight_sum, clock, reset, valid_ff, ((wx0_ff + wx1_ff) == One) && ((wy0_ff + wy1_ff) == One), "weight pair does not sum to one")

endmodule

>>> sv/brsn_lerp.sv
// Stages two and three: horizontal then vertical weighting of each channel.
`include "bilinear_rgb_sample_normalize_unit_macros.svh"

module brsn_lerp #(
   parameter int FRAC_BITS = brsn_pkg::FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [2:0][brsn_pkg::CHAN_W-1:0]        tl_chan,
   input  logic [2:0][brsn_pkg::CHAN_W-1:0]        tr_chan,
   input  logic [2:0][brsn_pkg::CHAN_W-1:0]        bl_chan,
   input  logic [2:0][brsn_pkg::CHAN_W-1:0]        br_chan,
   input  logic [FRAC_BITS:0]                      wx0,
   input  logic [FRAC_BITS:0]                      wx1,
   input  logic [FRAC_BITS:0]                      wy0,
   input  logic [FRAC_BITS:0]                      wy1,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [2:0][brsn_pkg::CHAN_W+2*FRAC_BITS:0] prod_top,
   output logic [2:0][brsn_pkg::CHAN_W+2*FRAC_BITS:0] prod_bot
);

   localparam int WeightW = FRAC_BITS + 1;
   localparam int TopW    = brsn_pkg::CHAN_W + FRAC_BITS;
   localparam int ProdW   = TopW + WeightW;

   logic                      h_valid_ff, h_valid_in, h_ready, h_load;
   logic                      v_valid_ff, v_valid_in, v_ready, v_load;
   logic [2:0][TopW-1:0]      top_ff, bot_ff, top_in, bot_in;
   logic [WeightW-1:0]        wy0_ff, wy1_ff;
   logic [2:0][ProdW-1:0]     ptop_ff, pbot_ff, ptop_in, pbot_in;
   logic [TopW:0]             top_full [3];
   logic [TopW:0]             bot_full [3];

   // Horizontal pass: each row sum fits TopW bits since it is at most 255 * 2^FRAC_BITS.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         top_full[c] = (TopW+1)'(tl_chan[c]) * (TopW+1)'(wx0)
                     + (TopW+1)'(tr_chan[c]) * (TopW+1)'(wx1);
         bot_full[c] = (TopW+1)'(bl_chan[c]) * (TopW+1)'(wx0)
                     + (TopW+1)'(br_chan[c]) * (TopW+1)'(wx1);
         top_in[c]   = top_full[c][TopW-1:0];
         bot_in[c]   = bot_full[c][TopW-1:0];
      end
   end

   // Vertical pass: register both products, the add follows downstream.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ptop_in[c] = ProdW'(top_ff[c]) * ProdW'(wy0_ff);
         pbot_in[c] = ProdW'(bot_ff[c]) * ProdW'(wy1_ff);
      end
   end

   assign v_ready    = !v_valid_ff || out_ready;
   assign h_ready    = !h_valid_ff || v_ready;
   assign in_ready   = h_ready;
   assign h_load     = in_valid && h_ready;
   assign v_load     = h_valid_ff && v_ready;
   assign h_valid_in = in_valid || (h_valid_ff && !v_ready);
   assign v_valid_in = h_valid_ff || (v_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= h_valid_in;
         v_valid_ff <= v_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (h_load) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         wy0_ff <= wy0;
         wy1_ff <= wy1;
      end
      if (v_load) begin
         ptop_ff <= ptop_in;
         pbot_ff <= pbot_in;
      end
   end

   assign out_valid = v_valid_ff;
   assign prod_top  = ptop_ff;
   assign prod_bot  = pbot_ff;

   `BRSN_ASSERT_NEXT(a_black_row, clock, reset, h_load && (tl_chan[0] == '0) && (tr_chan[0] == '0), top_ff[0] == '0, "black top row gave nonzero red sum")

endmodule

>>> sv/brsn_norm.sv
// Stages four and five: round and clamp to 8 bits, then mean/std normalize.
`include "bilinear_rgb_sample_normalize_unit_macros.svh"

module brsn_norm #(
   parameter int FRAC_BITS     = brsn_pkg::FRAC_BITS,
   parameter int OUT_FRAC_BITS = brsn_pkg::OUT_FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [2:0][brsn_pkg::CHAN_W+2*FRAC_BITS:0]  prod_top,
   input  logic [2:0][brsn_pkg::CHAN_W+2*FRAC_BITS:0]  prod_bot,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [2:0][brsn_pkg::NORM_W-1:0]            norm
);

   localparam int ProdW  = brsn_pkg::CHAN_W + 2*FRAC_BITS + 1;
   localparam int ShiftW = 2*FRAC_BITS;
   localparam int RoundW = ProdW + 1 - ShiftW;
   localparam logic [ProdW:0] Half = (ProdW+1)'(1) << (ShiftW - 1);
   localparam logic [RoundW-1:0] ChanMax = RoundW'(255);

   logic                                   c_valid_ff, c_valid_in, c_ready, c_load;
   logic                                   o_valid_ff, o_valid_in, o_ready, o_load;
   logic [ProdW:0]                         total [3];
   logic [RoundW-1:0]                      rounded [3];
   logic [2:0][brsn_pkg::CHAN_W-1:0]       chan_ff, chan_in;
   logic [2:0][brsn_pkg::NORM_W-1:0]       norm_ff, norm_in;
   logic [brsn_pkg::NORM_W-1:0]            norm_rom [3][256];

   // Normalization lookup, one entry per 8-bit code, built at elaboration.
   for (genvar gc = 0; gc < 3; gc++) begin : g_chan
      for (genvar gv = 0; gv < 256; gv++) begin : g_code
         localparam longint Num   = (longint'(gv) * 1000 - brsn_pkg::MEAN_MILLI[gc])
                                  * (longint'(1) << OUT_FRAC_BITS);
         localparam longint Numer = 2 * Num + brsn_pkg::STD_MILLI[gc];
         localparam longint Denom = 2 * brsn_pkg::STD_MILLI[gc];
         localparam longint Quot  = (Numer >= 0) ? (Numer / Denom)
                                                 : -((-Numer + Denom - 1) / Denom);
         localparam longint Sat   = (Quot > 32767) ? 32767
                                  : ((Quot < -32768) ? -32768 : Quot);
         assign norm_rom[gc][gv] = brsn_pkg::NORM_W'(Sat);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         total[c]   = (ProdW+1)'(prod_top[c]) + (ProdW+1)'(prod_bot[c]) + Half;
         rounded[c] = total[c][ProdW:ShiftW];
         chan_in[c] = (rounded[c] > ChanMax) ? 8'hFF : rounded[c][brsn_pkg::CHAN_W-1:0];
         norm_in[c] = norm_rom[c][chan_ff[c]];
      end
   end

   assign o_ready    = !o_valid_ff || out_ready;
   assign c_ready    = !c_valid_ff || o_ready;
   assign in_ready   = c_ready;
   assign c_load     = in_valid && c_ready;
   assign o_load     = c_valid_ff && o_ready;
   assign c_valid_in = in_valid || (c_valid_ff && !o_ready);
   assign o_valid_in = c_valid_ff || (o_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         chan_ff <= chan_in;
      end
      if (o_load) begin
         norm_ff <= norm_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign norm      = norm_ff;

   `BRSN_ASSERT_NEXT(a_clamp_high, clock, reset, c_load && (rounded[0] > ChanMax), chan_ff[0] == 8'hFF, "red code above range not clamped")

endmodule

>>> sv/bilinear_rgb_sample_normalize_unit.sv
// Top level of the bilinear RGB sampler with mean/std normalization.
//
// Usage:
//   req_bus carries one sample point a beat: signed corner, Q0.12 fractions and
//   the four neighboring stored pixels. rsp_bus returns one beat per request with
//   normalized red, green and blue in signed Q3.12, saturated to 16 bits.
//   csr_* writes frame width (index 0), frame height (index 1) and channel order
//   (index 2); write only while no request is in flight.
//   Pipeline: one register stage each for bounds/weights, horizontal multiply,
//   vertical multiply, round/clamp, and the normalization table lookup.
//   Throughput: one beat per cycle while rsp_bus.ready is high.
//   Reset: all stages empty, frame 1920x1080, byte order RGB.
//   Stall: when rsp_bus.ready is low the last stage holds its beat; earlier
//   empty stages keep taking requests, and req_bus.ready drops only once every
//   stage holds a beat.
module bilinear_rgb_sample_normalize_unit #(
   parameter int FRAC_BITS     = brsn_pkg::FRAC_BITS,
   parameter int OUT_FRAC_BITS = brsn_pkg::OUT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   brsn_req_if.sink                            req_bus,
   brsn_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [brsn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [brsn_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int ProdW = brsn_pkg::CHAN_W + 2*FRAC_BITS + 1;

   logic [brsn_pkg::DIM_W-1:0]          frame_width_ff, frame_height_ff;
   brsn_pkg::channel_order_type         channel_order_ff;

   logic                                w_valid, w_ready;
   logic [2:0][brsn_pkg::CHAN_W-1:0]    tl_chan, tr_chan, bl_chan, br_chan;
   logic [FRAC_BITS:0]                  wx0, wx1, wy0, wy1;
   logic                                l_valid, l_ready;
   logic [2:0][ProdW-1:0]               prod_top, prod_bot;
   logic [2:0][brsn_pkg::NORM_W-1:0]    norm;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= brsn_pkg::FRAME_WIDTH_RESET;
         frame_height_ff  <= brsn_pkg::FRAME_HEIGHT_RESET;
         channel_order_ff <= brsn_pkg::ORDER_RGB;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            brsn_pkg::CSR_FRAME_WIDTH:   frame_width_ff  <= csr_write_data;
            brsn_pkg::CSR_FRAME_HEIGHT:  frame_height_ff <= csr_write_data;
            brsn_pkg::CSR_CHANNEL_ORDER: begin
               channel_order_ff <= brsn_pkg::channel_order_type'(csr_write_data[0]);
            end
            default: ;
         endcase
      end
   end

   brsn_weight #(
      .FRAC_BITS (FRAC_BITS)
   ) u_weight (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_bus.valid),
      .in_ready           (req_bus.ready),
      .corner_x           (req_bus.corner_x),
      .corner_y           (req_bus.corner_y),
      .frac_x             (req_bus.frac_x),
      .frac_y             (req_bus.frac_y),
      .pixel_top_left     (req_bus.pixel_top_left),
      .pixel_top_right    (req_bus.pixel_top_right),
      .pixel_bottom_left  (req_bus.pixel_bottom_left),
      .pixel_bottom_right (req_bus.pixel_bottom_right),
      .frame_width        (frame_width_ff),
      .frame_height       (frame_height_ff),
      .channel_order      (channel_order_ff),
      .out_valid          (w_valid),
      .out_ready          (w_ready),
      .tl_chan            (tl_chan),
      .tr_chan            (tr_chan),
      .bl_chan            (bl_chan),
      .br_chan            (br_chan),
      .wx0                (wx0),
      .wx1                (wx1),
      .wy0                (wy0),
      .wy1                (wy1)
   );

   brsn_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_ready  (w_ready),
      .tl_chan   (tl_chan),
      .tr_chan   (tr_chan),
      .bl_chan   (bl_chan),
      .br_chan   (br_chan),
      .wx0       (wx0),
      .wx1       (wx1),
      .wy0       (wy0),
      .wy1       (wy1),
      .out_valid (l_valid),
      .out_ready (l_ready),
      .prod_top  (prod_top),
      .prod_bot  (prod_bot)
   );

   brsn_norm #(
      .FRAC_BITS     (FRAC_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l_valid),
      .in_ready  (l_ready),
      .prod_top  (prod_top),
      .prod_bot  (prod_bot),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .norm      (norm)
   );

   assign rsp_bus.norm_red   = norm[0];
   assign rsp_bus.norm_green = norm[1];
   assign rsp_bus.norm_blue  = norm[2];

endmodule
